[rtl/fbpg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the feedback probabilistic gate.
// No dependencies.
package fbpg_pkg;

  localparam int unsigned ROW_W    = 4;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned PROB_W   = 16;
  localparam int unsigned ADDR_W   = ROW_W + COL_W;
  localparam int unsigned TBL_DEPTH = 1 << ADDR_W;
  localparam int unsigned HIST_N   = 4;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned VAL_W    = PROB_W + 1;
  localparam int unsigned SUM_W    = VAL_W + COL_W;
  localparam int unsigned CFG_W    = 64;
  localparam logic [PROB_W-1:0] FLOOR_Q = 16'd66;

  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  localparam logic [2:0] REG_FB_EN      = 3'd0;
  localparam logic [2:0] REG_NUM_IN     = 3'd1;
  localparam logic [2:0] REG_NUM_OUT    = 3'd2;
  localparam logic [2:0] REG_POS_DEPTH  = 3'd3;
  localparam logic [2:0] REG_NEG_DEPTH  = 3'd4;
  localparam logic [2:0] REG_POS_LEVELS = 3'd5;
  localparam logic [2:0] REG_NEG_LEVELS = 3'd6;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } hist_t;

  typedef hist_t [HIST_N-1:0] hist_vec_t;

  typedef struct packed {
    hist_vec_t        h;
    logic [CNT_W-1:0] cnt;
  } push_t;

endpackage

[rtl/fbpg_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module fbpg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/feedback_probabilistic_gate.sv]
`timescale 1ns / 1ps
// Feedback probabilistic gate top level. Uses fbpg_pkg and fbpg_ram.
// Load and the unused opcode go straight to the result; restore copies the original table back.
// Step: each history pair is skipped or renormalized (row read, then one division per column unless
// the row sum is zero), then columns are drawn; one shared 17-step divider and one read port.
// One request at a time; the next is taken after the result is taken.
// Reset sets configuration to its defaults and clears histories and control; tables hold garbage until loaded.
module feedback_probabilistic_gate
  import fbpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [ROW_W-1:0]    in_bits_i,
  input  logic                pos_fb_active_i,
  input  logic                neg_fb_active_i,
  input  logic [PROB_W-1:0]   rand_choice_i,
  input  logic [63:0]         rand_pos_i,
  input  logic [63:0]         rand_neg_i,
  input  logic [ROW_W-1:0]    entry_row_i,
  input  logic [COL_W-1:0]    entry_col_i,
  input  logic [PROB_W-1:0]   entry_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [COL_W-1:0]    out_bits_o,
  output logic                fb_applied_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RESTORE, S_FB_SEL, S_FB_RADDR, S_FB_RDATA, S_FB_CHK,
    S_DIV_INIT, S_DIV, S_DR_ADDR, S_DR_DATA, S_PUSH, S_OUT
  } state_e;

  // configuration
  logic        fb_en_q;
  logic [2:0]  num_in_q, num_out_q, pos_depth_q, neg_depth_q;
  logic [63:0] pos_levels_q, neg_levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_en_q      <= 1'b1;
      num_in_q     <= 3'd1;
      num_out_q    <= 3'd1;
      pos_depth_q  <= 3'd0;
      neg_depth_q  <= 3'd0;
      pos_levels_q <= '0;
      neg_levels_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FB_EN:      fb_en_q      <= cfg_data_i[0];
        REG_NUM_IN:     num_in_q     <= cfg_data_i[2:0];
        REG_NUM_OUT:    num_out_q    <= cfg_data_i[2:0];
        REG_POS_DEPTH:  pos_depth_q  <= cfg_data_i[2:0];
        REG_NEG_DEPTH:  neg_depth_q  <= cfg_data_i[2:0];
        REG_POS_LEVELS: pos_levels_q <= cfg_data_i;
        REG_NEG_LEVELS: neg_levels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived geometry
  logic [COL_W:0]   ncols;
  logic [ROW_W-1:0] row_mask;

  always_comb begin
    unique case (num_out_q)
      3'd0, 3'd1: ncols = 5'd2;
      3'd2:       ncols = 5'd4;
      3'd3:       ncols = 5'd8;
      default:    ncols = 5'd16;
    endcase
    unique case (num_in_q)
      3'd0, 3'd1: row_mask = 4'h1;
      3'd2:       row_mask = 4'h3;
      3'd3:       row_mask = 4'h7;
      default:    row_mask = 4'hF;
    endcase
  end

  // push with trimming to depth
  function automatic push_t push_hist(hist_vec_t h, logic [CNT_W-1:0] cnt,
                                      logic [2:0] depth, hist_t e);
    hist_t       c [HIST_N+1];
    logic [3:0]  d, len, ncnt, off, src;
    push_t       res;
    for (int j = 0; j <= HIST_N; j++) begin
      c[j] = (j < 32'(cnt)) ? h[j] : e;
    end
    d    = (depth > 3'd4) ? 4'd4 : {1'b0, depth};
    len  = {1'b0, cnt} + 4'd1;
    ncnt = (len < d) ? len : d;
    off  = len - ncnt;
    res.h = h;
    for (int j = 0; j < HIST_N; j++) begin
      src = 4'(j) + off;
      if (src <= 4'd4) res.h[j] = c[src[2:0]];
    end
    res.cnt = ncnt[CNT_W-1:0];
    return res;
  endfunction

  // memories
  logic                prob_we, orig_we;
  logic [ADDR_W-1:0]   prob_waddr, prob_raddr, orig_waddr, orig_raddr;
  logic [PROB_W-1:0]   prob_wdata, orig_wdata, prob_rdata, orig_rdata;

  fbpg_ram #(.WIDTH(PROB_W), .DEPTH(TBL_DEPTH)) u_prob (
    .clk_i, .we_i(prob_we), .waddr_i(prob_waddr), .wdata_i(prob_wdata),
    .raddr_i(prob_raddr), .rdata_o(prob_rdata)
  );

  fbpg_ram #(.WIDTH(PROB_W), .DEPTH(TBL_DEPTH)) u_orig (
    .clk_i, .we_i(orig_we), .waddr_i(orig_waddr), .wdata_i(orig_wdata),
    .raddr_i(orig_raddr), .rdata_o(orig_rdata)
  );

  // datapath state
  state_e            state_q;
  logic [ROW_W-1:0]  in_bits_q;
  logic              pos_act_q, neg_act_q, neg_phase_q, applied_q;
  logic [PROB_W-1:0] rand_choice_q, mod_q, oldcol_q, draw_r_q;
  logic [63:0]       rand_pos_q, rand_neg_q;
  logic [2:0]        idx_q;
  hist_t             tgt_q;
  logic [COL_W-1:0]  k_q, draw_col_q;
  logic [VAL_W-1:0]  rowbuf_q [1 << COL_W];
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W:0]    rem_q;
  logic [PROB_W-1:0] quo_q;
  logic [4:0]        dcnt_q;
  logic [8:0]        rs_q;
  hist_vec_t         pos_hist_q, neg_hist_q;
  logic [CNT_W-1:0]  pos_cnt_q, neg_cnt_q;
  logic [COL_W-1:0]  out_bits_q;
  logic              fb_applied_q;

  // current pair
  hist_t             cur_ent;
  logic [CNT_W-1:0]  cur_cnt;
  logic              cur_go;
  logic [PROB_W-1:0] cur_rand, cur_level;
  logic [31:0]       prod;
  logic [VAL_W-1:0]  mod_val;
  logic [PROB_W-1:0] neg_v;
  logic              div_bit;
  logic [SUM_W:0]    div_rem;
  logic [VAL_W-1:0]  div_q;
  logic [PROB_W-1:0] div_sat, div_old;
  logic [ROW_W-1:0]  draw_row;
  push_t             pos_push, neg_push;

  always_comb begin
    cur_ent   = neg_phase_q ? neg_hist_q[idx_q[1:0]] : pos_hist_q[idx_q[1:0]];
    cur_cnt   = neg_phase_q ? neg_cnt_q : pos_cnt_q;
    cur_go    = neg_phase_q ? (fb_en_q && neg_depth_q != 3'd0 && neg_act_q)
                            : (fb_en_q && pos_depth_q != 3'd0 && pos_act_q);
    cur_rand  = neg_phase_q ? rand_neg_q[idx_q[1:0]*16 +: 16]
                            : rand_pos_q[idx_q[1:0]*16 +: 16];
    cur_level = neg_phase_q ? neg_levels_q[idx_q[1:0]*16 +: 16]
                            : pos_levels_q[idx_q[1:0]*16 +: 16];
    prod      = cur_rand * cur_level;

    // modified target entry
    if (neg_phase_q) begin
      neg_v   = (mod_q >= prob_rdata) ? '0 : prob_rdata - mod_q;
      if (neg_v < FLOOR_Q) neg_v = FLOOR_Q;
      mod_val = {1'b0, neg_v};
    end else begin
      neg_v   = '0;
      mod_val = {1'b0, prob_rdata} + {1'b0, mod_q};
    end

    // one restoring division step
    div_bit = (rem_q >= {1'b0, sum_q});
    div_rem = div_bit ? rem_q - {1'b0, sum_q} : rem_q;
    div_q   = {quo_q, div_bit};
    div_sat = div_q[VAL_W-1] ? '1 : div_q[PROB_W-1:0];
    div_old = (k_q == tgt_q.col) ? oldcol_q : rowbuf_q[k_q][PROB_W-1:0];

    draw_row = in_bits_q & row_mask;
    pos_push = push_hist(pos_hist_q, pos_cnt_q, pos_depth_q, '{row: draw_row, col: draw_col_q});
    neg_push = push_hist(neg_hist_q, neg_cnt_q, neg_depth_q, '{row: draw_row, col: draw_col_q});
  end

  // memory ports
  always_comb begin
    orig_we    = (state_q == S_IDLE) && in_valid_i && (opcode_i == OP_LOAD);
    orig_waddr = {entry_row_i, entry_col_i};
    orig_wdata = entry_value_i;
    orig_raddr = rs_q[ADDR_W-1:0];

    prob_we    = 1'b0;
    prob_waddr = {tgt_q.row, k_q};
    prob_wdata = div_sat;
    prob_raddr = {tgt_q.row, k_q};
    unique case (state_q)
      S_RESTORE: begin
        prob_we    = (rs_q != 9'd0);
        prob_waddr = 8'(rs_q - 9'd1);
        prob_wdata = orig_rdata;
      end
      S_DIV:     prob_we = (dcnt_q == 5'd16);
      S_DR_ADDR: prob_raddr = {draw_row, draw_col_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FB_RDATA) begin
      rowbuf_q[k_q] <= (k_q == tgt_q.col) ? mod_val : {1'b0, prob_rdata};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      in_bits_q     <= '0;
      pos_act_q     <= 1'b0;
      neg_act_q     <= 1'b0;
      neg_phase_q   <= 1'b0;
      applied_q     <= 1'b0;
      rand_choice_q <= '0;
      rand_pos_q    <= '0;
      rand_neg_q    <= '0;
      mod_q         <= '0;
      oldcol_q      <= '0;
      draw_r_q      <= '0;
      idx_q         <= '0;
      tgt_q         <= '0;
      k_q           <= '0;
      draw_col_q    <= '0;
      sum_q         <= '0;
      rem_q         <= '0;
      quo_q         <= '0;
      dcnt_q        <= '0;
      rs_q          <= '0;
      pos_hist_q    <= '0;
      neg_hist_q    <= '0;
      pos_cnt_q     <= '0;
      neg_cnt_q     <= '0;
      out_bits_q    <= '0;
      fb_applied_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_bits_q     <= in_bits_i;
            pos_act_q     <= pos_fb_active_i;
            neg_act_q     <= neg_fb_active_i;
            rand_choice_q <= rand_choice_i;
            rand_pos_q    <= rand_pos_i;
            rand_neg_q    <= rand_neg_i;
            out_bits_q    <= '0;
            fb_applied_q  <= 1'b0;
            applied_q     <= 1'b0;
            neg_phase_q   <= 1'b0;
            idx_q         <= '0;
            rs_q          <= '0;
            if (opcode_i == OP_STEP) begin
              state_q <= S_FB_SEL;
            end else if (opcode_i == OP_RESTORE) begin
              state_q <= S_RESTORE;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_RESTORE: begin
          rs_q <= rs_q + 9'd1;
          if (rs_q[8]) begin
            pos_cnt_q <= '0;
            neg_cnt_q <= '0;
            state_q   <= S_OUT;
          end
        end
        S_FB_SEL: begin
          if (!cur_go || idx_q >= cur_cnt) begin
            idx_q <= '0;
            if (!neg_phase_q) begin
              neg_phase_q <= 1'b1;
            end else begin
              draw_col_q <= '0;
              draw_r_q   <= rand_choice_q;
              state_q    <= S_DR_ADDR;
            end
          end else if ({1'b0, cur_ent.col} >= ncols) begin
            idx_q <= idx_q + 3'd1;
          end else begin
            tgt_q   <= cur_ent;
            mod_q   <= prod[31:16];
            k_q     <= '0;
            sum_q   <= '0;
            state_q <= S_FB_RADDR;
          end
        end
        S_FB_RADDR: state_q <= S_FB_RDATA;
        S_FB_RDATA: begin
          if (k_q == tgt_q.col) begin
            oldcol_q <= prob_rdata;
            sum_q    <= sum_q + SUM_W'(mod_val);
          end else begin
            sum_q    <= sum_q + SUM_W'(prob_rdata);
          end
          if ({1'b0, k_q} + 5'd1 == ncols) begin
            state_q <= S_FB_CHK;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= S_FB_RADDR;
          end
        end
        S_FB_CHK: begin
          k_q <= '0;
          if (sum_q == '0) begin
            idx_q   <= idx_q + 3'd1;
            state_q <= S_FB_SEL;
          end else begin
            state_q <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          rem_q   <= (SUM_W+1)'(rowbuf_q[k_q]);
          quo_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= {div_rem[SUM_W-1:0], 1'b0};
          quo_q  <= div_q[PROB_W-1:0];
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd16) begin
            if (div_sat != div_old) applied_q <= 1'b1;
            if ({1'b0, k_q} + 5'd1 == ncols) begin
              idx_q   <= idx_q + 3'd1;
              state_q <= S_FB_SEL;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_DIV_INIT;
            end
          end
        end
        S_DR_ADDR: state_q <= S_DR_DATA;
        S_DR_DATA: begin
          if (({1'b0, draw_col_q} + 5'd1 < ncols) && (draw_r_q > prob_rdata)) begin
            draw_r_q   <= draw_r_q - prob_rdata;
            draw_col_q <= draw_col_q + 4'd1;
            state_q    <= S_DR_ADDR;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (fb_en_q) begin
            pos_hist_q <= pos_push.h;
            pos_cnt_q  <= pos_push.cnt;
            neg_hist_q <= neg_push.h;
            neg_cnt_q  <= neg_push.cnt;
          end
          out_bits_q   <= draw_col_q;
          fb_applied_q <= applied_q;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign out_bits_o   = out_bits_q;
  assign fb_applied_o = fb_applied_q;

endmodule
